// ===== hdl/tccs_pkg.sv =====
`default_nettype none

package tccs_pkg;

  // Default geometry of video memory and screen
  localparam int unsigned VMEM_WORDS_DEF    = 16384;
  localparam int unsigned CONSOLE_COUNT_DEF = 3;
  localparam int unsigned SCREEN_WIDTH_DEF  = 80;
  localparam int unsigned SCREEN_CELLS_DEF  = 2000;

  // Address width on the output side
  localparam int OUT_AW = 14;

  // Special character codes
  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [7:0] CH_SPACE     = 8'd32;

  // Register map: bit 2 of the byte address selects the register slot
  localparam logic       REG_CHAR_ATTR = 1'b0;
  localparam logic [7:0] ATTR_RESET    = 8'd7;

  typedef enum logic [1:0] {
    KIND_PUT    = 2'd0,
    KIND_UP     = 2'd1,
    KIND_DOWN   = 2'd2,
    KIND_SELECT = 2'd3
  } kind_t;

  // Datapath micro-operations
  typedef enum logic [2:0] {
    U_NOP,
    U_CHAR,
    U_NEWLINE,
    U_BACKSP,
    U_SCROLL,
    U_SCR_UP,
    U_SCR_DN,
    U_SELECT
  } uop_t;

  // Sequencer jump conditions
  typedef enum logic [1:0] {
    J_NEXT,
    J_ALWAYS,
    J_DISPATCH,
    J_NEED
  } cond_t;

  localparam int PC_W = 4;

  // Program labels
  localparam logic [PC_W-1:0] PC_DISP   = 4'd0;
  localparam logic [PC_W-1:0] PC_CHAR   = 4'd1;
  localparam logic [PC_W-1:0] PC_NL     = 4'd2;
  localparam logic [PC_W-1:0] PC_BS     = 4'd3;
  localparam logic [PC_W-1:0] PC_SCROLL = 4'd4;
  localparam logic [PC_W-1:0] PC_FINISH = 4'd5;
  localparam logic [PC_W-1:0] PC_UP     = 4'd6;
  localparam logic [PC_W-1:0] PC_DOWN   = 4'd7;
  localparam logic [PC_W-1:0] PC_SEL    = 4'd8;

  typedef struct packed {
    uop_t            op;
    cond_t           cond;
    logic [PC_W-1:0] target;
    logic            last;
  } ctl_t;

  // Status flags from datapath to sequencer
  typedef struct packed {
    logic  bad;
    kind_t kind;
    logic  is_nl;
    logic  is_bs;
    logic  need_scroll;
  } stat_t;

  typedef struct packed {
    logic              mem_write;
    logic [OUT_AW-1:0] mem_addr;
    logic [7:0]        mem_char;
    logic [7:0]        mem_attr;
    logic              display_update;
    logic [OUT_AW-1:0] cursor_pos;
    logic [OUT_AW-1:0] view_start;
    logic              ignored;
  } res_t;

  // Control store
  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    case (pc)
      PC_DISP:   w = '{op: U_NOP,     cond: J_DISPATCH, target: PC_DISP,   last: 1'b0};
      PC_CHAR:   w = '{op: U_CHAR,    cond: J_ALWAYS,   target: PC_SCROLL, last: 1'b0};
      PC_NL:     w = '{op: U_NEWLINE, cond: J_ALWAYS,   target: PC_SCROLL, last: 1'b0};
      PC_BS:     w = '{op: U_BACKSP,  cond: J_NEXT,     target: PC_SCROLL, last: 1'b0};
      PC_SCROLL: w = '{op: U_SCROLL,  cond: J_NEED,     target: PC_SCROLL, last: 1'b0};
      PC_FINISH: w = '{op: U_NOP,     cond: J_NEXT,     target: PC_FINISH, last: 1'b1};
      PC_UP:     w = '{op: U_SCR_UP,  cond: J_ALWAYS,   target: PC_FINISH, last: 1'b0};
      PC_DOWN:   w = '{op: U_SCR_DN,  cond: J_ALWAYS,   target: PC_FINISH, last: 1'b0};
      PC_SEL:    w = '{op: U_SELECT,  cond: J_ALWAYS,   target: PC_FINISH, last: 1'b0};
      default:   w = '{op: U_NOP,     cond: J_NEXT,     target: PC_FINISH, last: 1'b1};
    endcase
    return w;
  endfunction

  // Entry point of the routine for one item
  function automatic logic [PC_W-1:0] dispatch(input stat_t st);
    logic [PC_W-1:0] t;
    if (st.bad) begin
      t = PC_FINISH;
    end else begin
      case (st.kind)
        KIND_PUT:    t = st.is_nl ? PC_NL : (st.is_bs ? PC_BS : PC_CHAR);
        KIND_UP:     t = PC_UP;
        KIND_DOWN:   t = PC_DOWN;
        KIND_SELECT: t = PC_SEL;
        default:     t = PC_FINISH;
      endcase
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tccs_seq.sv =====
`default_nettype none

module tccs_seq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic           stall,
  input  tccs_pkg::stat_t stat,
  output tccs_pkg::ctl_t  ctl,
  output logic           step_en,
  output logic           finish,
  output logic           busy
);
  import tccs_pkg::*;

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  logic            busy_next;

  // Fetch the control word and pick the next step
  always_comb begin
    ctl     = ucode(pc);
    step_en = busy && !(ctl.last && stall);
    finish  = step_en && ctl.last;
    case (ctl.cond)
      J_NEXT:     pc_next = pc + 4'd1;
      J_ALWAYS:   pc_next = ctl.target;
      J_DISPATCH: pc_next = dispatch(stat);
      J_NEED:     pc_next = stat.need_scroll ? ctl.target : pc + 4'd1;
      default:    pc_next = pc + 4'd1;
    endcase
    busy_next = busy;
    if (start) begin
      busy_next = 1'b1;
      pc_next   = PC_DISP;
    end else if (!step_en) begin
      pc_next = pc;
    end else if (ctl.last) begin
      busy_next = 1'b0;
      pc_next   = PC_DISP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc   <= PC_DISP;
      busy <= 1'b0;
    end else begin
      pc   <= pc_next;
      busy <= busy_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tccs_dp.sv =====
`default_nettype none

module tccs_dp #(
  parameter int unsigned VMEM_WORDS    = tccs_pkg::VMEM_WORDS_DEF,
  parameter int unsigned CONSOLE_COUNT = tccs_pkg::CONSOLE_COUNT_DEF,
  parameter int unsigned SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_CELLS  = tccs_pkg::SCREEN_CELLS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            load,
  input  tccs_pkg::kind_t kind,
  input  logic [2:0]      console_index,
  input  logic [7:0]      char_code,
  input  logic [7:0]      char_attribute,
  input  tccs_pkg::ctl_t  ctl,
  input  logic            step_en,
  input  logic            finish,
  output tccs_pkg::stat_t stat,
  output tccs_pkg::res_t  res
);
  import tccs_pkg::*;

  localparam int unsigned SLICE = VMEM_WORDS / CONSOLE_COUNT;
  localparam int AW  = $clog2(VMEM_WORDS + SCREEN_CELLS + SCREEN_WIDTH + 1);
  localparam int CIW = (CONSOLE_COUNT > 1) ? $clog2(CONSOLE_COUNT) : 1;
  localparam logic [AW-1:0] SLICE_A = AW'(SLICE);
  localparam logic [AW-1:0] LINE_A  = AW'(SCREEN_WIDTH);
  localparam logic [AW-1:0] CELLS_A = AW'(SCREEN_CELLS);

  // Per-console state; line_store keeps the start of the cursor's line
  logic [AW-1:0]  cursor_store [CONSOLE_COUNT];
  logic [AW-1:0]  view_store   [CONSOLE_COUNT];
  logic [AW-1:0]  line_store   [CONSOLE_COUNT];
  logic [CIW-1:0] current;

  // Working registers of the item in flight
  kind_t          kind_r;
  logic [7:0]     ch_r;
  logic [CIW-1:0] idx_r;
  logic           bad_r;
  logic [AW-1:0]  cur;
  logic [AW-1:0]  start;
  logic [AW-1:0]  line;
  logic [AW-1:0]  base;
  logic [AW-1:0]  lim;
  logic           wr;
  logic [AW-1:0]  waddr;
  logic [7:0]     wchar;

  logic           bad_in;
  logic [CIW-1:0] sel;
  logic [AW-1:0]  base_in;
  logic [AW-1:0]  cur_inc;
  logic [AW-1:0]  cur_dec;
  logic [AW-1:0]  line_next;
  logic [AW-1:0]  view_end;
  logic           need;
  logic           upd;

  // Decode the console number of an incoming item
  always_comb begin
    bad_in  = {1'b0, console_index} >= 4'(CONSOLE_COUNT);
    sel     = bad_in ? '0 : console_index[CIW-1:0];
    base_in = AW'(sel) * SLICE_A;
  end

  always_comb begin
    cur_inc   = cur + AW'(1);
    cur_dec   = cur - AW'(1);
    line_next = line + LINE_A;
    view_end  = start + CELLS_A;
    need      = (cur >= view_end) && (view_end < lim);
  end

  // Load the item, then apply one micro-operation per step
  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind;
      ch_r   <= char_code;
      idx_r  <= sel;
      bad_r  <= bad_in;
      cur    <= cursor_store[sel];
      start  <= view_store[sel];
      line   <= line_store[sel];
      base   <= base_in;
      lim    <= base_in + SLICE_A;
      wr     <= 1'b0;
      waddr  <= '0;
      wchar  <= '0;
    end else if (step_en) begin
      case (ctl.op)
        U_CHAR: begin
          if (cur_inc < lim) begin
            wr    <= 1'b1;
            waddr <= cur;
            wchar <= ch_r;
            cur   <= cur_inc;
            if (cur_inc == line_next) line <= line_next;
          end
        end
        U_NEWLINE: begin
          if (cur + LINE_A < lim) begin
            cur  <= line_next;
            line <= line_next;
          end
        end
        U_BACKSP: begin
          if (cur > base) begin
            wr    <= 1'b1;
            waddr <= cur_dec;
            wchar <= CH_SPACE;
            cur   <= cur_dec;
            if (cur_dec < line) line <= line - LINE_A;
          end
        end
        U_SCROLL: begin
          if (need) start <= start + LINE_A;
        end
        U_SCR_UP: begin
          if (start > base) start <= start - LINE_A;
        end
        U_SCR_DN: begin
          if (view_end < lim) start <= start + LINE_A;
        end
        default: begin
        end
      endcase
    end
  end

  // Write back console state at the end of an item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < CONSOLE_COUNT; c++) begin
        cursor_store[c] <= AW'(c) * SLICE_A;
        view_store[c]   <= AW'(c) * SLICE_A;
        line_store[c]   <= AW'(c) * SLICE_A;
      end
      current <= '0;
    end else begin
      if (finish && !bad_r) begin
        cursor_store[idx_r] <= cur;
        view_store[idx_r]   <= start;
        line_store[idx_r]   <= line;
      end
      if (step_en && ctl.op == U_SELECT) current <= idx_r;
    end
  end

  // Status and result
  always_comb begin
    upd                = !bad_r && (current == idx_r);
    stat.bad           = bad_r;
    stat.kind          = kind_r;
    stat.is_nl         = ch_r == CH_NEWLINE;
    stat.is_bs         = ch_r == CH_BACKSPACE;
    stat.need_scroll   = need;
    res.mem_write      = wr && !bad_r;
    res.mem_addr       = res.mem_write ? OUT_AW'(waddr) : '0;
    res.mem_char       = res.mem_write ? wchar : '0;
    res.mem_attr       = res.mem_write ? char_attribute : '0;
    res.display_update = upd;
    res.cursor_pos     = upd ? OUT_AW'(cur) : '0;
    res.view_start     = upd ? OUT_AW'(start) : '0;
    res.ignored        = bad_r;
  end

endmodule

`default_nettype wire

// ===== hdl/text_console_cursor_scroll.sv =====
// A character, newline or backspace runs dispatch, its operation, a scroll step
// repeated while the view must scroll, and finish; scroll and select items run
// dispatch, their operation and finish; an item with an out-of-range console runs
// dispatch and finish. One item in flight at a time; the next is taken the cycle
// after the result is registered. A waiting result holds the last step.
// Synchronous reset: cursors and view starts at slice base, console 0, attribute 7.
`default_nettype none

module text_console_cursor_scroll #(
  parameter int unsigned VMEM_WORDS    = tccs_pkg::VMEM_WORDS_DEF,
  parameter int unsigned CONSOLE_COUNT = tccs_pkg::CONSOLE_COUNT_DEF,
  parameter int unsigned SCREEN_WIDTH  = tccs_pkg::SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_CELLS  = tccs_pkg::SCREEN_CELLS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // console_index[2:0], char_code[10:3]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  // mem_addr[13:0], mem_char[21:14], mem_attr[29:22], cursor_pos[43:30],
  // view_start[57:44]
  output logic [63:0] m_tdata,
  output logic [2:0]  m_tuser,   // mem_write[0], display_update[1], ignored[2]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tccs_pkg::*;

  logic [7:0] char_attribute;
  logic       load;
  logic       stall;
  logic       step_en;
  logic       finish;
  logic       busy;
  ctl_t       ctl;
  stat_t      stat;
  res_t       res;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CHAR_ATTR) ? {24'd0, char_attribute} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CHAR_ATTR) begin
      char_attribute <= pwdata[7:0];
    end
  end

  // Input handshake
  assign s_tready = !busy;
  assign load     = s_tvalid && s_tready;
  assign stall    = m_tvalid && !m_tready;

  tccs_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (load),
    .stall   (stall),
    .stat    (stat),
    .ctl     (ctl),
    .step_en (step_en),
    .finish  (finish),
    .busy    (busy)
  );

  tccs_dp #(
    .VMEM_WORDS    (VMEM_WORDS),
    .CONSOLE_COUNT (CONSOLE_COUNT),
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_CELLS  (SCREEN_CELLS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .load           (load),
    .kind           (kind_t'(s_tuser)),
    .console_index  (s_tdata[2:0]),
    .char_code      (s_tdata[10:3]),
    .char_attribute (char_attribute),
    .ctl            (ctl),
    .step_en        (step_en),
    .finish         (finish),
    .stat           (stat),
    .res            (res)
  );

  // Output register; hold the item until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      m_tdata <= {6'd0, res.view_start, res.cursor_pos, res.mem_attr, res.mem_char,
                  res.mem_addr};
      m_tuser <= {res.ignored, res.display_update, res.mem_write};
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tccs_checker.sv =====
`default_nettype none

module tccs_checker (
  input wire        clk,
  input wire        rst,
  input wire        s_tvalid,
  input wire        s_tready,
  input wire        m_tvalid,
  input wire        m_tready,
  input wire [63:0] m_tdata,
  input wire [2:0]  m_tuser
);

  // An ignored item carries nothing else
  a_ignored_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == 2'b00 && m_tdata == 64'd0)
    else $error("ignored item carries data");

  // Memory fields are zero without a write
  a_mem_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[29:0] == 30'd0)
    else $error("memory fields set without write");

  // Display fields are zero without an update
  a_disp_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[1] |-> m_tdata[57:30] == 28'd0)
    else $error("display fields set without update");

  // One item in flight: no accept in the cycle after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted while item in flight");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

endmodule

bind text_console_cursor_scroll tccs_checker u_chk (.*);

`default_nettype wire

// ===== dv/testbench.sv =====
`default_nettype none

module testbench;
  import tccs_pkg::*;

  localparam int unsigned CONSOLES       = CONSOLE_COUNT_DEF;
  localparam int unsigned SLICE          = VMEM_WORDS_DEF / CONSOLE_COUNT_DEF;
  localparam int unsigned LINE           = SCREEN_WIDTH_DEF;
  localparam int unsigned PAGE           = SCREEN_CELLS_DEF;
  localparam int          CYCLE_LIMIT    = 1000000;
  localparam int          HOLD_CYCLES    = 300;
  localparam int          DRAIN_CYCLES   = 12;
  localparam logic [2:0]  ADDR_CHAR_ATTR = {REG_CHAR_ATTR, 2'b00};

  // Console state tracker and store of pending display results
  class console_scoreboard;
    int unsigned cursor [CONSOLES];
    int unsigned view [CONSOLES];
    int unsigned current;
    logic [7:0]  attr;
    res_t        pending_q [$];
    int          errors;

    function new();
      for (int c = 0; c < CONSOLES; c++) begin
        cursor[c] = c * SLICE;
        view[c]   = c * SLICE;
      end
      current = 0;
      attr    = ATTR_RESET;
      errors  = 0;
    endfunction

    function int pending();
      return pending_q.size();
    endfunction

    function void report(string what, longint unsigned want, longint unsigned got);
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0h, got %0h", what, want, got);
    endfunction

    // Advance the console state for one accepted item and queue its result
    function void note_item(kind_t kind, logic [2:0] idx, logic [7:0] ch);
      int unsigned base, lim, cur, start;
      res_t r;
      r = '0;
      if (idx >= CONSOLES) begin
        r.ignored = 1'b1;
        pending_q.push_back(r);
        return;
      end
      base  = idx * SLICE;
      lim   = base + SLICE;
      cur   = cursor[idx];
      start = view[idx];
      case (kind)
        KIND_PUT: begin
          if (ch == CH_NEWLINE) begin
            if (cur + LINE < lim)
              cur = base + LINE * ((cur - base) / LINE + 1);
          end else if (ch == CH_BACKSPACE) begin
            if (cur > base) begin
              cur--;
              r.mem_write = 1'b1;
              r.mem_addr  = OUT_AW'(cur);
              r.mem_char  = CH_SPACE;
              r.mem_attr  = attr;
            end
          end else if (cur + 1 < lim) begin
            r.mem_write = 1'b1;
            r.mem_addr  = OUT_AW'(cur);
            r.mem_char  = ch;
            r.mem_attr  = attr;
            cur++;
          end
          // Scroll down until the cursor is on screen
          while (cur >= start + PAGE && start + PAGE < lim)
            start += LINE;
        end
        KIND_UP: begin
          if (start > base)
            start -= LINE;
        end
        KIND_DOWN: begin
          if (start + PAGE < lim)
            start += LINE;
        end
        default: begin
          current = idx;
        end
      endcase
      cursor[idx] = cur;
      view[idx]   = start;
      if (current == idx) begin
        r.display_update = 1'b1;
        r.cursor_pos     = OUT_AW'(cur);
        r.view_start     = OUT_AW'(start);
      end
      pending_q.push_back(r);
    endfunction

    // Compare one display result against the oldest pending one
    function void check_result(res_t got);
      res_t want;
      if (pending_q.size() == 0) begin
        report("result with nothing pending", 0, got);
        return;
      end
      want = pending_q.pop_front();
      if (got.mem_write !== want.mem_write)
        report("mem_write", want.mem_write, got.mem_write);
      if (got.mem_addr !== want.mem_addr)
        report("mem_addr", want.mem_addr, got.mem_addr);
      if (got.mem_char !== want.mem_char)
        report("mem_char", want.mem_char, got.mem_char);
      if (got.mem_attr !== want.mem_attr)
        report("mem_attr", want.mem_attr, got.mem_attr);
      if (got.display_update !== want.display_update)
        report("display_update", want.display_update, got.display_update);
      if (got.cursor_pos !== want.cursor_pos)
        report("cursor_pos", want.cursor_pos, got.cursor_pos);
      if (got.view_start !== want.view_start)
        report("view_start", want.view_start, got.view_start);
      if (got.ignored !== want.ignored)
        report("ignored", want.ignored, got.ignored);
    endfunction
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [15:0] s_tdata  = '0;   // console_index[2:0], char_code[10:3]
  logic [1:0]  s_tuser  = '0;   // kind[1:0]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  // mem_addr[13:0], mem_char[21:14], mem_attr[29:22], cursor_pos[43:30],
  // view_start[57:44]
  logic [63:0] m_tdata;
  logic [2:0]  m_tuser;          // mem_write[0], display_update[1], ignored[2]
  logic        psel     = 1'b0;
  logic        penable  = 1'b0;
  logic        pwrite   = 1'b0;
  logic [2:0]  paddr    = '0;
  logic [31:0] pwdata   = '0;
  logic [31:0] prdata;
  logic        pready;

  console_scoreboard sb = new();

  int   src_idle_pct = 0;
  int   snk_idle_pct = 0;
  int   sent_valid   = 0;
  int   hold_reqs    = 0;
  int   hold_done    = 0;
  int   stall_left   = 0;
  int   cycles       = 0;
  res_t seen;

  text_console_cursor_scroll u_top (.*);

  always #10 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("text_console_cursor_scroll test failed");
      $finish;
    end
  end

  // Take results, stall at random, hold off for a long stretch on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen                = '0;
        seen.mem_write      = m_tuser[0];
        seen.display_update = m_tuser[1];
        seen.ignored        = m_tuser[2];
        seen.mem_addr       = m_tdata[13:0];
        seen.mem_char       = m_tdata[21:14];
        seen.mem_attr       = m_tdata[29:22];
        seen.cursor_pos     = m_tdata[43:30];
        seen.view_start     = m_tdata[57:44];
        sb.check_result(seen);
      end
      if (stall_left == 0 && hold_done != hold_reqs) begin
        stall_left = HOLD_CYCLES;
        hold_done++;
      end
      if (stall_left > 0) begin
        stall_left--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Offer one item and wait for its handshake; valid stays high afterwards
  task automatic send_item(kind_t kind, logic [2:0] idx, logic [7:0] ch);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {5'b0, ch, idx};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_item(kind, idx, ch);
    if (idx < CONSOLES) sent_valid++;
  endtask

  // Drop valid and wait until every pending result has come back
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Write the attribute register while idle, then read it back
  task automatic write_attr(logic [7:0] value);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_CHAR_ATTR;
    pwdata  <= {24'b0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    sb.attr = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[7:0] !== sb.attr)
      sb.report("char_attribute readback", sb.attr, prdata[7:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Bursts of typical console traffic with some noise mixed in
  task automatic random_traffic(int count);
    int         target, mode, len;
    logic [2:0] con;
    logic [7:0] ch;
    kind_t      kind;
    target = sent_valid + count;
    while (sent_valid < target) begin
      mode = $urandom_range(99);
      con  = 3'($urandom_range(CONSOLES - 1));
      if (mode < 40) begin
        // text line with occasional line breaks
        len = $urandom_range(1, 100);
        for (int i = 0; i < len; i++) begin
          ch = ($urandom_range(9) == 0) ? CH_NEWLINE : 8'($urandom_range(255));
          send_item(KIND_PUT, con, ch);
        end
      end else if (mode < 55) begin
        len = $urandom_range(1, 30);
        for (int i = 0; i < len; i++) send_item(KIND_PUT, con, CH_NEWLINE);
      end else if (mode < 65) begin
        len = $urandom_range(1, 10);
        for (int i = 0; i < len; i++) send_item(KIND_PUT, con, CH_BACKSPACE);
      end else if (mode < 80) begin
        len  = $urandom_range(1, 50);
        kind = $urandom_range(1) ? KIND_UP : KIND_DOWN;
        for (int i = 0; i < len; i++) send_item(kind, con, 8'($urandom_range(255)));
      end else if (mode < 88) begin
        send_item(KIND_SELECT, con, 8'($urandom_range(255)));
      end else begin
        len = $urandom_range(1, 5);
        for (int i = 0; i < len; i++)
          send_item(kind_t'($urandom_range(3)), 3'($urandom_range(7)),
                    8'($urandom_range(255)));
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: field extremes, special characters, bounds, every kind
    send_item(KIND_PUT, 3'd0, 8'd65);
    send_item(KIND_PUT, 3'd0, 8'h00);
    send_item(KIND_PUT, 3'd0, 8'hFF);
    send_item(KIND_PUT, 3'd0, CH_BACKSPACE);
    send_item(KIND_PUT, 3'd0, CH_NEWLINE);
    send_item(KIND_PUT, 3'd0, CH_BACKSPACE);
    send_item(KIND_PUT, 3'd1, CH_BACKSPACE);
    send_item(KIND_PUT, 3'd2, 8'h55);
    send_item(KIND_UP, 3'd0, 8'h00);
    send_item(KIND_DOWN, 3'd0, 8'hFF);
    send_item(KIND_UP, 3'd0, 8'h00);
    send_item(KIND_DOWN, 3'd2, 8'h00);
    send_item(KIND_SELECT, 3'd1, 8'h00);
    send_item(KIND_PUT, 3'd1, CH_NEWLINE);
    send_item(KIND_SELECT, 3'd2, 8'hFF);
    send_item(KIND_SELECT, 3'd3, 8'h00);
    send_item(KIND_SELECT, 3'd7, 8'hFF);
    send_item(KIND_PUT, 3'd4, 8'h41);
    send_item(KIND_UP, 3'd5, 8'h00);
    send_item(KIND_DOWN, 3'd6, 8'hFF);
    send_item(KIND_SELECT, 3'd0, 8'h00);
    send_item(KIND_PUT, 3'd0, 8'hAA);

    // Sender idles often, receiver more, with one long receiver hold-off
    write_attr(8'hFF);
    src_idle_pct = 34;
    snk_idle_pct = 54;
    random_traffic(300);
    hold_reqs++;
    random_traffic(333);

    // Roles swapped, with one full drain in the middle
    write_attr(8'h00);
    src_idle_pct = 54;
    snk_idle_pct = 34;
    random_traffic(300);
    wait_drained();
    random_traffic(333);

    // Full rate on both sides
    write_attr(8'($urandom_range(1, 254)));
    src_idle_pct = 0;
    snk_idle_pct = 0;
    random_traffic(634);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("text_console_cursor_scroll test passed");
    end else begin
      $display("text_console_cursor_scroll test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
